>>> design/lgg_pkg.sv
package lgg_pkg;

  // Number of row slots kept in the ring.
  localparam int SLOTS = 4;

  typedef logic [31:0] word_t;
  typedef logic [1:0] slot_t;
  typedef logic [SLOTS-1:0][31:0] row_word_t;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_DRAIN  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    REG_ROW_LENGTH   = 2'd0,
    REG_ROW_COUNT    = 2'd1,
    REG_WRAP_COLUMNS = 2'd2,
    REG_INV_DY       = 2'd3
  } cfg_idx_e;

endpackage

>>> design/lgg_if.sv
// Sample input channel.
interface lgg_in_if;
  import lgg_pkg::*;
  logic  valid;
  logic  ready;
  logic  cmd;
  word_t sample;
  word_t row_inv_dx;
  modport source (output valid, output cmd, output sample, output row_inv_dx, input ready);
  modport sink (input valid, input cmd, input sample, input row_inv_dx, output ready);
endinterface

// Gradient output channel.
interface lgg_out_if;
  import lgg_pkg::*;
  logic  valid;
  logic  ready;
  word_t grad_x;
  word_t grad_y;
  logic  last;
  modport source (output valid, output grad_x, output grad_y, output last, input ready);
  modport sink (input valid, input grad_x, input grad_y, input last, output ready);
endinterface

// Configuration write channel.
interface lgg_cfg_if;
  import lgg_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_e index;
  word_t    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/lgg_row_mem.sv
// Row ring store: one wide word per column holds all four ring slots.
// Two copies are kept so that three columns can be read per cycle.
module lgg_row_mem import lgg_pkg::*; #(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  slot_t         wr_slot,
  input  word_t         wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] left_addr,
  input  logic [AW-1:0] right_addr,
  input  logic [AW-1:0] mid_addr,
  output row_word_t     left_data,
  output row_word_t     right_data,
  output row_word_t     mid_data
);

  row_word_t side_mem [DEPTH];
  row_word_t mid_mem [DEPTH];

  // Both copies take the same slot write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      side_mem[wr_addr][wr_slot] <= wr_data;
      mid_mem[wr_addr][wr_slot]  <= wr_data;
    end
  end

  // Registered reads; held while the consumer stage is stalled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      left_data  <= side_mem[left_addr];
      right_data <= side_mem[right_addr];
      mid_data   <= mid_mem[mid_addr];
    end
  end

endmodule

>>> design/latlon_grid_gradient.sv
// Channel   Dir  Transfer when         Payload
// samples   in   valid && ready        cmd, sample, row_inv_dx
// grads     out  valid && ready        grad_x, grad_y, last
// cfg       in   valid && ready        index, data (ready is always high)
//
// One item is accepted per cycle while samples.ready is high; a result passes
// through the registered row-store read, the multiply and the saturate stage.
// The three stages collapse bubbles, so input is taken while a result waits.
// Reset is synchronous; the row store holds no reset and needs no clearing pass.
// Rows 0 and 1 and ignored items produce no result.
module latlon_grid_gradient import lgg_pkg::*; #(
  parameter int MAX_COLS  = 1024,
  parameter int FRAC_BITS = 40
) (
  input logic clk,
  input logic rst,
  lgg_in_if.sink    samples,
  lgg_out_if.source grads,
  lgg_cfg_if.sink   cfg
);

  localparam int CW = $clog2(MAX_COLS);
  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

  typedef struct packed {
    slot_t se;
    slot_t hi;
    slot_t lo;
    logic  first_row;
    logic  zero;
    logic  last;
    word_t fwd;
    word_t scale;
  } s1_ctrl_t;

  // Configuration registers.
  logic [10:0] row_length;
  logic [15:0] row_count;
  logic        wrap_columns;
  word_t       inv_dy;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length   <= 11'd1024;
      row_count    <= 16'd512;
      wrap_columns <= 1'b1;
      inv_dy       <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ROW_LENGTH:   row_length   <= cfg.data[10:0];
        REG_ROW_COUNT:    row_count    <= cfg.data[15:0];
        REG_WRAP_COLUMNS: wrap_columns <= cfg.data[0];
        REG_INV_DY:       inv_dy       <= cfg.data;
        default:          ;
      endcase
    end
  end

  // Clamped row length (as last column) and row count.
  logic [CW-1:0] len_m1;
  logic [16:0]   rows;

  always_comb begin
    logic [31:0] rl;
    logic [31:0] lm1;
    rl = {21'd0, row_length};
    if (rl < 32'd3) lm1 = 32'd2;
    else if (rl > 32'(MAX_COLS)) lm1 = 32'(MAX_COLS - 1);
    else lm1 = rl - 32'd1;
    len_m1 = lm1[CW-1:0];
    rows = (row_count < 16'd3) ? 17'd3 : {1'b0, row_count};
  end

  // Position counters; the ring head is the low bits of the row counter.
  logic [CW-1:0] col;
  logic [16:0]   row_idx;
  slot_t         head;
  word_t         row_scale [SLOTS];

  assign head = row_idx[1:0];

  // Stage handshake.
  logic v1, v2, v3;
  logic adv1, adv2, adv3;
  logic accept;

  assign adv3 = !v3 || grads.ready;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign samples.ready = adv1;
  assign accept = samples.valid && adv1;

  // Decode of the incoming item.
  logic          is_drain, live, emit, wr_en;
  logic          left_edge, right_edge, first_row, last_row;
  logic [CW-1:0] col_l, col_r;
  slot_t         se, hi, lo;

  always_comb begin
    is_drain   = samples.cmd == CMD_DRAIN;
    live       = is_drain ? (row_idx >= rows) : (row_idx < rows);
    emit       = is_drain || (row_idx >= 17'd2);
    wr_en      = accept && live && !is_drain;
    left_edge  = col == '0;
    right_edge = col >= len_m1;
    col_l      = left_edge ? len_m1 : col - CW'(1);
    col_r      = right_edge ? '0 : col + CW'(1);
    first_row  = row_idx == 17'd2;
    last_row   = row_idx >= rows + 17'd1;
    se         = head + 2'd2;
    if (first_row) begin
      hi = head;
      lo = se;
    end else if (last_row) begin
      hi = se;
      lo = head;
    end else begin
      hi = head + 2'd3;
      lo = head + 2'd1;
    end
  end

  // Counter update and row scale capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row_idx <= '0;
    end else if (accept && live) begin
      if (right_edge) begin
        col <= '0;
        if (row_idx + 17'd1 >= rows + 17'd2) row_idx <= '0;
        else row_idx <= row_idx + 17'd1;
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) row_scale[head] <= samples.row_inv_dx;
  end

  // Row store.
  row_word_t left_data, right_data, mid_data;

  lgg_row_mem #(.DEPTH(MAX_COLS)) u_mem (
    .clk        (clk),
    .wr_en      (wr_en),
    .wr_addr    (col),
    .wr_slot    (head),
    .wr_data    (samples.sample),
    .rd_en      (adv1),
    .left_addr  (col_l),
    .right_addr (col_r),
    .mid_addr   (col),
    .left_data  (left_data),
    .right_data (right_data),
    .mid_data   (mid_data)
  );

  // Stage 1: control travels alongside the memory read.
  s1_ctrl_t s1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv1) v1 <= accept && live && emit;
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1.se        <= se;
      s1.hi        <= hi;
      s1.lo        <= lo;
      s1.first_row <= first_row;
      s1.zero      <= !wrap_columns && (left_edge || right_edge);
      s1.last      <= last_row && right_edge;
      s1.fwd       <= samples.sample;
      s1.scale     <= row_scale[se];
    end
  end

  // Differences; the top neighbor of row 0 is the sample arriving with it.
  logic signed [32:0] dx, dy;
  word_t              hi_v;

  always_comb begin
    hi_v = s1.first_row ? s1.fwd : mid_data[s1.hi];
    dx = $signed({right_data[s1.se][31], right_data[s1.se]})
       - $signed({left_data[s1.se][31], left_data[s1.se]});
    dy = $signed({hi_v[31], hi_v}) - $signed({mid_data[s1.lo][31], mid_data[s1.lo]});
  end

  // Stage 2: products.
  logic signed [65:0] px, py;
  logic               s2_zero, s2_last;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv2) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      px      <= dx * $signed({1'b0, s1.scale});
      py      <= dy * $signed({1'b0, inv_dy});
      s2_zero <= s1.zero;
      s2_last <= s1.last;
    end
  end

  // Floor shift and saturation to 32 signed bits.
  function automatic word_t sat_shift(input logic signed [65:0] p);
    logic signed [65:0] q;
    q = p >>> FRAC_BITS;
    if (q > SAT_MAX) return 32'h7FFF_FFFF;
    if (q < SAT_MIN) return 32'h8000_0000;
    return q[31:0];
  endfunction

  // Stage 3: output register.
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv3) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      grads.grad_x <= s2_zero ? '0 : sat_shift(px);
      grads.grad_y <= s2_zero ? '0 : sat_shift(py);
      grads.last   <= s2_last;
    end
  end

  assign grads.valid = v3;

endmodule
